// ===== rtl/fkp_pkg.sv =====
// Shared types and constants of the five-key press classifier.
package fkp_pkg;

    localparam int KEY_COUNT  = 5;
    localparam int HOLD_W     = 8;
    localparam int VOL_W      = 7;
    localparam int CMD_W      = 3;
    localparam int SLOT_COUNT = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Key positions in key_levels (key n sits at bit n-1)
    localparam int KEY_2 = 1;
    localparam int KEY_3 = 2;
    localparam int KEY_4 = 3;
    localparam int KEY_5 = 4;

    // Result slots in emission order
    localparam int SLOT_KEY2     = 0;
    localparam int SLOT_STOP_REC = 1;
    localparam int SLOT_KEY3     = 2;
    localparam int SLOT_KEY4     = 3;
    localparam int SLOT_KEY5     = 4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_STEP      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_CEILING   = 2'd2;

    localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RST = 8'd25;
    localparam logic [VOL_W-1:0]  VOLUME_STEP_RST      = 7'd5;
    localparam logic [VOL_W-1:0]  VOLUME_CEILING_RST   = 7'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOGGLE_PLAY     = 3'd0,
        CMD_STOP_ALARM      = 3'd1,
        CMD_STOP_REC        = 3'd2,
        CMD_NEXT            = 3'd3,
        CMD_PREVIOUS        = 3'd4,
        CMD_START_RAW       = 3'd5,
        CMD_START_RESAMPLED = 3'd6,
        CMD_SET_VOLUME      = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [HOLD_W-1:0] long_press_ticks;
        logic [VOL_W-1:0]  volume_step;
        logic [VOL_W-1:0]  volume_ceiling;
    } cfg_t;

    typedef struct packed {
        cmd_t             command;
        logic [VOL_W-1:0] new_volume;
    } result_t;

endpackage

// ===== rtl/fkp_keys.sv =====
// Per-key edge and hold tracking, and the command slots that one tick produces.
module fkp_keys (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic [fkp_pkg::KEY_COUNT-1:0] key_levels,
    input  logic                          alarm_playing,
    input  logic                          recording_active,
    input  logic [fkp_pkg::VOL_W-1:0]     current_volume,
    input  fkp_pkg::cfg_t                 cfg,
    output logic [fkp_pkg::SLOT_COUNT-1:0] slot_valid,
    output fkp_pkg::result_t              slot_data [fkp_pkg::SLOT_COUNT]
);
    import fkp_pkg::*;

    logic              level_reg [KEY_COUNT];
    logic              level_next [KEY_COUNT];
    logic [HOLD_W-1:0] hold_reg [KEY_COUNT];
    logic [HOLD_W-1:0] hold_next [KEY_COUNT];
    logic              long_fired_reg [KEY_COUNT];
    logic              long_fired_next [KEY_COUNT];
    logic              stop_consumed_reg;
    logic              stop_consumed_next;

    logic [KEY_COUNT-1:0] press_ev;
    logic [KEY_COUNT-1:0] hold_ev;
    logic [KEY_COUNT-1:0] fire_ev;
    logic [KEY_COUNT-1:0] short_rel;
    logic [HOLD_W-1:0]    hold_inc [KEY_COUNT];

    logic [VOL_W:0]   vol_sum;
    logic [VOL_W-1:0] vol_up;
    logic [VOL_W-1:0] vol_mid;
    logic [VOL_W-1:0] vol_down;

    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            press_ev[i]  = key_levels[i] & ~level_reg[i];
            hold_ev[i]   = key_levels[i] & level_reg[i];
            short_rel[i] = ~key_levels[i] & level_reg[i] & ~long_fired_reg[i];
            // count up, saturate at the threshold
            hold_inc[i]  = (hold_reg[i] < cfg.long_press_ticks) ? hold_reg[i] + 8'd1
                                                                 : hold_reg[i];
            fire_ev[i]   = hold_ev[i] & (hold_inc[i] >= cfg.long_press_ticks)
                         & ~long_fired_reg[i];

            level_next[i] = key_levels[i];
            if (press_ev[i]) begin
                hold_next[i]       = '0;
                long_fired_next[i] = 1'b0;
            end else if (hold_ev[i]) begin
                hold_next[i]       = hold_inc[i];
                long_fired_next[i] = long_fired_reg[i] | fire_ev[i];
            end else begin
                hold_next[i]       = hold_reg[i];
                long_fired_next[i] = long_fired_reg[i];
            end
        end
        stop_consumed_next = press_ev[KEY_2] ? recording_active : stop_consumed_reg;
    end

    // Volume chain: key 3 raises first, key 5 lowers from that result
    always_comb begin
        vol_sum  = {1'b0, current_volume} + {1'b0, cfg.volume_step};
        vol_up   = (vol_sum < {1'b0, cfg.volume_ceiling}) ? vol_sum[VOL_W-1:0]
                                                          : cfg.volume_ceiling;
        vol_mid  = short_rel[KEY_3] ? vol_up : current_volume;
        vol_down = (vol_mid > cfg.volume_step) ? vol_mid - cfg.volume_step : '0;
    end

    always_comb begin
        slot_valid[SLOT_KEY2] = (press_ev[KEY_2] & alarm_playing)
                              | ((fire_ev[KEY_2] | short_rel[KEY_2]) & ~stop_consumed_reg);
        if (press_ev[KEY_2]) begin
            slot_data[SLOT_KEY2].command = CMD_STOP_ALARM;
        end else if (fire_ev[KEY_2]) begin
            slot_data[SLOT_KEY2].command = CMD_START_RAW;
        end else begin
            slot_data[SLOT_KEY2].command = CMD_START_RESAMPLED;
        end
        slot_data[SLOT_KEY2].new_volume = '0;

        slot_valid[SLOT_STOP_REC]           = press_ev[KEY_2] & recording_active;
        slot_data[SLOT_STOP_REC].command    = CMD_STOP_REC;
        slot_data[SLOT_STOP_REC].new_volume = '0;

        slot_valid[SLOT_KEY3]           = fire_ev[KEY_3] | short_rel[KEY_3];
        slot_data[SLOT_KEY3].command    = fire_ev[KEY_3] ? CMD_NEXT : CMD_SET_VOLUME;
        slot_data[SLOT_KEY3].new_volume = fire_ev[KEY_3] ? '0 : vol_up;

        slot_valid[SLOT_KEY4]           = press_ev[KEY_4];
        slot_data[SLOT_KEY4].command    = CMD_TOGGLE_PLAY;
        slot_data[SLOT_KEY4].new_volume = '0;

        slot_valid[SLOT_KEY5]           = fire_ev[KEY_5] | short_rel[KEY_5];
        slot_data[SLOT_KEY5].command    = fire_ev[KEY_5] ? CMD_PREVIOUS : CMD_SET_VOLUME;
        slot_data[SLOT_KEY5].new_volume = fire_ev[KEY_5] ? '0 : vol_down;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                level_reg[i]      <= 1'b0;
                hold_reg[i]       <= '0;
                long_fired_reg[i] <= 1'b0;
            end
            stop_consumed_reg <= 1'b0;
        end else if (load) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                level_reg[i]      <= level_next[i];
                hold_reg[i]       <= hold_next[i];
                long_fired_reg[i] <= long_fired_next[i];
            end
            stop_consumed_reg <= stop_consumed_next;
        end
    end

endmodule

// ===== rtl/fkp_out_buf.sv =====
// Result register: holds the command slots of one tick and sends them out in order.
module fkp_out_buf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [fkp_pkg::SLOT_COUNT-1:0] slot_valid,
    input  fkp_pkg::result_t               slot_data [fkp_pkg::SLOT_COUNT],
    output logic                           can_load,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fkp_pkg::result_t               out_data,
    output logic                           out_last
);
    import fkp_pkg::*;

    logic [SLOT_COUNT-1:0] mask_reg;
    logic [SLOT_COUNT-1:0] mask_next;
    result_t               data_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] pick;
    logic [SLOT_COUNT-1:0] rest;
    logic                  xfer;

    always_comb begin
        // lowest pending slot goes first
        pick      = mask_reg & (~mask_reg + 1'b1);
        rest      = mask_reg & ~pick;
        out_valid = |mask_reg;
        out_last  = ~|rest;
        xfer      = out_valid & out_ready;
        can_load  = ~out_valid | (out_last & out_ready);
        out_data  = data_reg[0];
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (pick[i]) begin
                out_data = data_reg[i];
            end
        end
        if (load) begin
            mask_next = slot_valid;
        end else if (xfer) begin
            mask_next = rest;
        end else begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                data_reg[i] <= slot_data[i];
            end
        end
    end

endmodule

// ===== rtl/five_key_press_classifier.sv =====
// Top level of the five-key press classifier: config registers, key tracking, result register.
//
//  channel  | direction | handshake        | payload
//  s_       | in        | s_tvalid/tready  | s_tdata: key_levels, alarm_playing,
//           |           |                  |          recording_active, current_volume
//  m_       | out       | m_tvalid/tready  | m_tdata: command, new_volume; m_tlast: last
//  cfg_     | in        | cfg_we           | cfg_addr, cfg_wdata
//
// A tick is evaluated in the cycle it is accepted; its commands (zero to five) sit in
// the result register and leave one per cycle while m_tready is high, lowest key first.
// The next tick is taken in the cycle the last command of the previous one transfers.
// Reset (aresetn low, synchronous) releases all keys, clears hold state and restores
// the register defaults. A stall on m_ holds the current command and blocks s_.
module five_key_press_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] key_levels, [5] alarm_playing, [6] recording_active,
    // [13:7] current_volume, [15:14] zero
    input  logic [fkp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] command, [9:3] new_volume, [15:10] zero
    output logic [fkp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [fkp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fkp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fkp_pkg::*;

    cfg_t    cfg_reg;
    logic    load;
    logic    can_load;
    result_t out_data;

    logic [SLOT_COUNT-1:0] slot_valid;
    result_t               slot_data [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.volume_step      <= VOLUME_STEP_RST;
            cfg_reg.volume_ceiling   <= VOLUME_CEILING_RST;
        end else if (cfg_we) begin
            // out-of-range index: drop the write
            unique case (cfg_addr)
                CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_wdata;
                CFG_VOLUME_STEP:      cfg_reg.volume_step      <= cfg_wdata[VOL_W-1:0];
                CFG_VOLUME_CEILING:   cfg_reg.volume_ceiling   <= cfg_wdata[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = can_load;
    assign load     = s_tvalid & can_load;

    fkp_keys u_keys (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .key_levels       (s_tdata[KEY_COUNT-1:0]),
        .alarm_playing    (s_tdata[KEY_COUNT]),
        .recording_active (s_tdata[KEY_COUNT+1]),
        .current_volume   (s_tdata[KEY_COUNT+2+VOL_W-1:KEY_COUNT+2]),
        .cfg              (cfg_reg),
        .slot_valid       (slot_valid),
        .slot_data        (slot_data)
    );

    fkp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .slot_valid (slot_valid),
        .slot_data  (slot_data),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - CMD_W - VOL_W){1'b0}}, out_data.new_volume,
                      out_data.command};

endmodule

// ===== rtl/fkp_checker.sv =====
// Port-level checks of the five-key press classifier, bound to the top level.
module fkp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fkp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import fkp_pkg::*;

    // Reset leaves no pending command and an open input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pending command or blocked input after reset");

    // A new tick is taken only while the final command of the previous one is shown.
    a_load_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast && m_tready)
        else $error("input taken while earlier commands still pending");

    // Only set volume carries a volume.
    a_volume_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CMD_W-1:0] != CMD_SET_VOLUME)
        |-> m_tdata[CMD_W+VOL_W-1:CMD_W] == '0)
        else $error("nonzero volume on a command other than set volume");

    // A stalled command holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled command changed");

endmodule

bind five_key_press_classifier fkp_checker u_fkp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
